// File: rtl/core/rwg_pkg.sv
`default_nettype none
package rwg_pkg;

  localparam int MAX_TAPS = 64;
  localparam int ADDR_W   = 6;
  localparam int RAW_W    = 32;
  localparam int IDX_W    = 16;
  localparam int TAP_W    = 6;
  localparam int WGT_W    = 16;
  localparam int ACC_W    = 40;
  localparam int STAT_W   = 2;
  localparam int CIDX_W   = 3;
  localparam int CDAT_W   = 16;
  localparam int NUM_W    = 64;
  localparam int DEN_W    = 40;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_TAPS = 2'd1,
    ST_SUM  = 2'd2
  } status_t;

  localparam logic [CIDX_W-1:0] REG_INPUT_LENGTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_OUTPUT_LENGTH = 3'd1;
  localparam logic [CIDX_W-1:0] REG_KERNEL_KIND   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BLUR_INVERSE  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SUPPORT       = 3'd4;
  localparam logic [CIDX_W-1:0] REG_CUBIC_B       = 3'd5;
  localparam logic [CIDX_W-1:0] REG_CUBIC_C       = 3'd6;
  localparam logic [CIDX_W-1:0] REG_NEG_GAIN      = 3'd7;

  localparam logic [1:0] KIND_FLEX     = 2'd0;
  localparam logic [1:0] KIND_FAST     = 2'd1;
  localparam logic [1:0] KIND_TRIANGLE = 2'd2;
  localparam logic [1:0] KIND_BOX      = 2'd3;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic        [DEN_W-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

// File: rtl/core/rwg_if.sv
`default_nettype none
interface rwg_pixel_if import rwg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] output_index;
  modport source(output valid, output output_index, input ready);
  modport sink(input valid, input output_index, output ready);
endinterface

interface rwg_weight_if import rwg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        left_source;
  logic [IDX_W-1:0]        right_source;
  logic [TAP_W-1:0]        tap_offset;
  logic signed [WGT_W-1:0] tap_weight;
  logic                    last_tap;
  logic [STAT_W-1:0]       status;
  logic [ACC_W-1:0]        negative_total;
  logic [ACC_W-1:0]        positive_total;
  modport source(output valid, output left_source, output right_source, output tap_offset,
                 output tap_weight, output last_tap, output status,
                 output negative_total, output positive_total, input ready);
  modport sink(input valid, input left_source, input right_source, input tap_offset,
               input tap_weight, input last_tap, input status,
               input negative_total, input positive_total, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rwg_ram.sv
`default_nettype none
module rwg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/rwg_mul.sv
`default_nettype none
module rwg_mul import rwg_pkg::*; (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [17:0] b,
  output logic      signed [50:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

// File: rtl/core/rwg_div.sv
`default_nettype none
module rwg_div import rwg_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire div_req_t                req,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quot
);
  logic             busy;
  logic [5:0]       cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] dvd;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   rem_sh;
  logic             bit_q;
  logic [NUM_W-1:0] q_fin;

  always_comb begin
    mag    = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    rem_sh = {rem, dvd[NUM_W-1]};
    bit_q  = rem_sh >= {1'b0, den_r};
    q_fin  = {dvd[NUM_W-2:0], bit_q};
  end

  // floor division: negative numerators are biased by den-1 and negated back
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        den_r <= req.den;
        neg_r <= req.num[NUM_W-1];
        dvd   <= req.num[NUM_W-1] ? mag + NUM_W'(req.den) - NUM_W'(1) : mag;
      end else if (busy) begin
        rem <= bit_q ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        dvd <= q_fin;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg_r ? -$signed(q_fin) : $signed(q_fin);
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/resample_weight_generator.sv
// Channel     Dir  Payload
// pixel_in    in   output_index
// weight_out  out  left/right_source, tap_offset, tap_weight, last_tap, status, totals
// cfg_*       in   register write, index cfg_index, data cfg_data
// One pixel at a time; pixel_in.ready is high only between pixels.
// Downscaling adds window and per-tap scaling divisions; cubic kernels add Horner
// steps per tap, and flex cubic a reciprocal multiply for /6. All divisions use the
// one 64-step divider shared by centre, window, scaling and normalisation.
// Synchronous reset clears sequencer, output valid and totals; registers take defaults.
// A stalled output holds the sequencer only when the next result is ready.
`default_nettype none
module resample_weight_generator import rwg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  rwg_pixel_if.sink              pixel_in,
  rwg_weight_if.source           weight_out,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CDAT_W-1:0] cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE, S_C_MUL, S_C_DIV, S_C_WAIT, S_H_MUL, S_H_DIV, S_H_WAIT, S_EDGES, S_CHECK,
    S_T_START, S_D_MUL0, S_D_MUL1, S_D_MUL2, S_D_DIV, S_D_WAIT, S_B_MUL0, S_B_MUL1,
    S_B_MUL2, S_T_CAP, S_KERN, S_H_STEP, S_H_ADD, S_6_WAIT, S_6_MUL0, S_6_MUL1,
    S_6_MUL2, S_6_FIN, S_GAIN, S_G_ADD,
    S_STORE, S_W_SETUP, S_W_READ, S_W_DIV, S_W_WAIT, S_EMIT_W, S_EMIT_E
  } state_t;

  state_t state;

  logic [15:0]        inl, outl, blur, gain;
  logic [1:0]         kind;
  logic [14:0]        sw;
  logic signed [15:0] cb, cc;

  logic [IDX_W-1:0]   u_r;
  logic signed [51:0] center, hw;
  logic signed [36:0] left_r, right_r, bound_r;
  logic [6:0]         cnt7, k;
  logic [40:0]        mag;
  logic               neg_r;
  logic [57:0]        macc;
  logic [20:0]        t;
  logic               far;
  logic signed [32:0] acc, r;
  logic [1:0]         step;
  logic signed [39:0] sum;
  status_t            stat_r;
  logic [ACC_W-1:0]   nacc, pacc;
  logic               six_neg;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  div_req_t           dreq;
  logic               ddone;
  logic signed [63:0] dq;
  logic               ram_we;
  logic [RAW_W-1:0]   ram_rd;

  logic [15:0]        outl_eff;
  logic               down, ofree, emit_now;
  logic signed [36:0] le, re, left_n, right_n, bound_n, inlm1, count;
  logic signed [52:0] d, absd;
  logic signed [32:0] bx, cx, a0, coef;
  logic signed [32:0] tri_v, hnext;
  logic signed [32:0] x6, y6;
  logic [18:0]        win;
  logic signed [63:0] wq;
  logic signed [15:0] wsat;
  logic signed [16:0] w17;

  rwg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  rwg_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dq));
  rwg_ram #(.WIDTH(RAW_W), .DEPTH(MAX_TAPS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(k[ADDR_W-1:0]), .wdata(r[RAW_W-1:0]),
    .raddr(k[ADDR_W-1:0]), .rdata(ram_rd)
  );

  assign pixel_in.ready = (state == S_IDLE);
  assign ofree = !weight_out.valid || weight_out.ready;
  assign emit_now = ofree && (state == S_EMIT_W || state == S_EMIT_E);

  always_comb begin
    outl_eff = (outl == 16'd0) ? 16'd1 : outl;
    down     = outl_eff < inl;
    le       = 37'((center - hw + 52'sd32768) >>> 16);
    re       = 37'((center + hw + 52'sd32767) >>> 16);
    inlm1    = $signed({21'b0, inl}) - 37'sd1;
    left_n   = (le > 37'sd0) ? le : 37'sd0;
    right_n  = (re < inlm1) ? re : inlm1;
    bound_n  = 37'(((hw <<< 1) - 52'sd2 + 52'sd65535) >>> 16) + 37'sd1;
    count    = right_r - left_r + 37'sd1;
    d        = $signed({left_r + $signed({30'b0, k}), 16'b0}) - 53'(center);
    absd     = d[52] ? -d : d;
    bx       = 33'(cb);
    cx       = 33'(cc);
    win      = {sw, 4'b0};
    tri_v    = $signed({16'b0, (17'd65538 - {1'b0, t[15:0]}) >> 2});
    // Horner coefficients, times six for the flex cubic
    a0   = '0;
    coef = '0;
    if (kind == KIND_FLEX) begin
      if (!far) begin
        a0 = 33'sd196608 - 33'sd9 * bx - 33'sd6 * cx;
        unique case (step)
          2'd0:    coef = 33'sd6 * (33'sd2 * bx + cx - 33'sd49152);
          2'd1:    coef = '0;
          default: coef = 33'sd98304 - 33'sd2 * bx;
        endcase
      end else begin
        a0 = -bx - 33'sd6 * cx;
        unique case (step)
          2'd0:    coef = 33'sd6 * bx + 33'sd30 * cx;
          2'd1:    coef = -33'sd48 * cx - 33'sd12 * bx;
          default: coef = 33'sd8 * bx + 33'sd24 * cx;
        endcase
      end
    end else begin
      if (!far) begin
        a0 = 33'sd16384;
        unique case (step)
          2'd0:    coef = -33'sd32768;
          2'd1:    coef = '0;
          default: coef = 33'sd16384;
        endcase
      end else begin
        a0 = -33'sd16384;
        unique case (step)
          2'd0:    coef = 33'sd81920;
          2'd1:    coef = -33'sd131072;
          default: coef = 33'sd65536;
        endcase
      end
    end
    hnext = 33'(mul_p >>> 16) + coef;
    // floor(x/6) for negative x is -floor((5 - x)/6)
    x6    = hnext + 33'sd3;
    y6    = x6[32] ? 33'sd5 - x6 : x6;
    wq    = dq;
    if (wq > 64'sd32767) begin
      wsat = 16'sh7fff;
    end else if (wq < -64'sd32768) begin
      wsat = -16'sh8000;
    end else begin
      wsat = wq[15:0];
    end
    w17 = 17'(wsat);
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    dreq   = '0;
    ram_we = (state == S_STORE);
    unique case (state)
      S_C_MUL: begin
        mul_a = $signed({16'b0, u_r, 1'b1});
        mul_b = $signed({2'b0, inl});
      end
      S_H_MUL: begin
        mul_a = $signed({15'b0, sw, 3'b0});
        mul_b = $signed({2'b0, inl});
      end
      S_D_MUL0: begin
        mul_a = $signed({9'b0, mag[23:0]});
        mul_b = $signed({2'b0, outl_eff});
      end
      S_D_MUL1: begin
        mul_a = $signed({16'b0, mag[40:24]});
        mul_b = $signed({2'b0, outl_eff});
      end
      S_B_MUL0: begin
        mul_a = $signed({9'b0, mag[23:0]});
        mul_b = $signed({2'b0, blur});
      end
      S_B_MUL1: begin
        mul_a = $signed({16'b0, mag[40:24]});
        mul_b = $signed({2'b0, blur});
      end
      S_H_STEP: begin
        mul_a = acc;
        mul_b = $signed({1'b0, t[16:0]});
      end
      // ceil(2^29 / 6), exact for magnitudes below 2^27
      S_6_MUL0: begin
        mul_a = 33'sd89478486;
        mul_b = $signed({1'b0, mag[16:0]});
      end
      S_6_MUL1: begin
        mul_a = 33'sd89478486;
        mul_b = $signed({8'b0, mag[26:17]});
      end
      S_GAIN: begin
        mul_a = r;
        mul_b = $signed({2'b0, gain});
      end
      S_C_DIV: begin
        dreq.start = 1'b1;
        dreq.num   = 64'(mul_p) <<< 16;
        dreq.den   = {23'b0, outl_eff, 1'b0};
      end
      S_H_DIV: begin
        dreq.start = 1'b1;
        dreq.num   = 64'(mul_p);
        dreq.den   = {24'b0, outl_eff};
      end
      S_D_DIV: begin
        dreq.start = 1'b1;
        dreq.num   = $signed({6'b0, macc});
        dreq.den   = {24'b0, inl};
      end
      S_W_DIV: begin
        dreq.start = 1'b1;
        dreq.num   = (64'($signed(ram_rd)) <<< 15) + 64'(sum);
        dreq.den   = {sum[38:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inl  <= 16'd1;
      outl <= 16'd1;
      kind <= KIND_FLEX;
      blur <= 16'd4096;
      sw   <= 15'd8192;
      cb   <= 16'sd0;
      cc   <= 16'sd8192;
      gain <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_LENGTH:  inl  <= cfg_data;
        REG_OUTPUT_LENGTH: outl <= cfg_data;
        REG_KERNEL_KIND:   kind <= cfg_data[1:0];
        REG_BLUR_INVERSE:  blur <= cfg_data;
        REG_SUPPORT:       sw   <= cfg_data[14:0];
        REG_CUBIC_B:       cb   <= $signed(cfg_data);
        REG_CUBIC_C:       cc   <= $signed(cfg_data);
        REG_NEG_GAIN:      gain <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      weight_out.valid <= 1'b0;
      nacc             <= '0;
      pacc             <= '0;
    end else begin
      if (weight_out.valid && weight_out.ready && !emit_now) begin
        weight_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pixel_in.valid) begin
            u_r   <= pixel_in.output_index;
            state <= S_C_MUL;
          end
        end
        S_C_MUL:  state <= S_C_DIV;
        S_C_DIV:  state <= S_C_WAIT;
        S_C_WAIT: begin
          if (ddone) begin
            center <= 52'(dq) - 52'sd32768;
            state  <= S_H_MUL;
          end
        end
        S_H_MUL: begin
          if (down) begin
            state <= S_H_DIV;
          end else begin
            hw    <= $signed({34'b0, sw, 3'b0});
            state <= S_EDGES;
          end
        end
        S_H_DIV:  state <= S_H_WAIT;
        S_H_WAIT: begin
          if (ddone) begin
            hw    <= 52'(dq);
            state <= S_EDGES;
          end
        end
        S_EDGES: begin
          left_r  <= left_n;
          right_r <= right_n;
          bound_r <= bound_n;
          state   <= S_CHECK;
        end
        S_CHECK: begin
          cnt7 <= count[6:0];
          k    <= '0;
          sum  <= '0;
          if (count < 37'sd0 || count > 37'sd64 || count > bound_r) begin
            stat_r <= ST_TAPS;
            state  <= S_EMIT_E;
          end else if (count == 37'sd0) begin
            stat_r <= ST_SUM;
            state  <= S_EMIT_E;
          end else begin
            state <= S_T_START;
          end
        end
        S_T_START: begin
          neg_r <= d[52];
          mag   <= (absd > 53'sh100_0000_0000) ? 41'h100_0000_0000 : absd[40:0];
          state <= down ? S_D_MUL0 : S_B_MUL0;
        end
        S_D_MUL0: state <= S_D_MUL1;
        S_D_MUL1: begin
          macc  <= {18'b0, mul_p[39:0]};
          state <= S_D_MUL2;
        end
        S_D_MUL2: begin
          macc  <= macc + ({25'b0, mul_p[32:0]} << 24);
          state <= S_D_DIV;
        end
        S_D_DIV:  state <= S_D_WAIT;
        S_D_WAIT: begin
          if (ddone) begin
            mag   <= dq[40:0];
            state <= S_B_MUL0;
          end
        end
        S_B_MUL0: state <= S_B_MUL1;
        S_B_MUL1: begin
          macc  <= {18'b0, mul_p[39:0]};
          state <= S_B_MUL2;
        end
        S_B_MUL2: begin
          macc  <= macc + ({25'b0, mul_p[32:0]} << 24);
          state <= S_T_CAP;
        end
        S_T_CAP: begin
          t     <= (macc[57:12] > 46'h10_0000) ? 21'h10_0000 : macc[32:12];
          state <= S_KERN;
        end
        S_KERN: begin
          far  <= t >= 21'h1_0000;
          step <= 2'd0;
          if (kind == KIND_BOX) begin
            r     <= (neg_r ? (t <= {2'b0, win}) : (t < {2'b0, win})) ? 33'sd16384 : 33'sd0;
            state <= S_GAIN;
          end else if (kind == KIND_TRIANGLE) begin
            r     <= (t < 21'h1_0000) ? tri_v : 33'sd0;
            state <= S_GAIN;
          end else if (t >= 21'h2_0000) begin
            r     <= '0;
            state <= S_GAIN;
          end else begin
            state <= S_H_ADD;
          end
        end
        S_H_ADD: begin
          // far is valid from here on; load the leading coefficient
          acc   <= a0;
          state <= S_H_STEP;
        end
        S_H_STEP: state <= S_6_WAIT;
        S_6_WAIT: begin
          acc  <= hnext;
          step <= step + 2'd1;
          if (step == 2'd2) begin
            if (kind == KIND_FLEX) begin
              mag     <= {8'b0, y6};
              six_neg <= x6[32];
              state   <= S_6_MUL0;
            end else begin
              r     <= hnext;
              state <= S_GAIN;
            end
          end else begin
            state <= S_H_STEP;
          end
        end
        S_6_MUL0: state <= S_6_MUL1;
        S_6_MUL1: begin
          macc  <= {14'b0, mul_p[43:0]};
          state <= S_6_MUL2;
        end
        S_6_MUL2: begin
          macc  <= macc + ({21'b0, mul_p[36:0]} << 17);
          state <= S_6_FIN;
        end
        S_6_FIN: begin
          r     <= six_neg ? -$signed({4'b0, macc[57:29]}) : $signed({4'b0, macc[57:29]});
          state <= S_GAIN;
        end
        S_GAIN: begin
          state <= (r < 33'sd0 && gain != 16'd0) ? S_G_ADD : S_STORE;
        end
        S_G_ADD: begin
          r     <= 33'((mul_p + 51'sd2048) >>> 12);
          state <= S_STORE;
        end
        S_STORE: begin
          sum <= sum + 40'(r);
          if (k + 7'd1 == cnt7) begin
            state <= S_W_SETUP;
          end else begin
            k     <= k + 7'd1;
            state <= S_T_START;
          end
        end
        S_W_SETUP: begin
          k <= '0;
          if (sum <= 40'sd0) begin
            stat_r <= ST_SUM;
            state  <= S_EMIT_E;
          end else begin
            state <= S_W_READ;
          end
        end
        S_W_READ: state <= S_W_DIV;
        S_W_DIV:  state <= S_W_WAIT;
        S_W_WAIT: begin
          if (ddone) begin
            state <= S_EMIT_W;
          end
        end
        S_EMIT_W: begin
          if (ofree) begin
            weight_out.valid        <= 1'b1;
            weight_out.left_source  <= left_r[15:0];
            weight_out.right_source <= right_r[15:0];
            weight_out.tap_offset   <= k[TAP_W-1:0];
            weight_out.tap_weight   <= wsat;
            weight_out.last_tap     <= (k + 7'd1 == cnt7);
            weight_out.status       <= ST_OK;
            if (wsat < 16'sd0) begin
              nacc                      <= nacc + {23'b0, 17'(-w17)};
              weight_out.negative_total <= nacc + {23'b0, 17'(-w17)};
              weight_out.positive_total <= pacc;
            end else begin
              pacc                      <= pacc + {24'b0, wsat};
              weight_out.positive_total <= pacc + {24'b0, wsat};
              weight_out.negative_total <= nacc;
            end
            if (k + 7'd1 == cnt7) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 7'd1;
              state <= S_W_READ;
            end
          end
        end
        S_EMIT_E: begin
          if (ofree) begin
            weight_out.valid          <= 1'b1;
            weight_out.left_source    <= left_r[15:0];
            weight_out.right_source   <= right_r[15:0];
            weight_out.tap_offset     <= '0;
            weight_out.tap_weight     <= '0;
            weight_out.last_tap       <= 1'b1;
            weight_out.status         <= stat_r;
            weight_out.negative_total <= nacc;
            weight_out.positive_total <= pacc;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/rwg_checker.sv
`default_nettype none
module rwg_checker import rwg_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [WGT_W-1:0] tap_weight,
  input wire logic                    last_tap,
  input wire logic [STAT_W-1:0]       status
);
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a pixel while busy");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_tap && tap_weight == '0)
    else $error("error result not final or nonzero weight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_TAPS || status == ST_SUM)
    else $error("bad status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tap_weight) && $stable(status))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind resample_weight_generator rwg_checker u_rwg_checker (
  .clk(clk), .rst(rst),
  .in_valid(pixel_in.valid), .in_ready(pixel_in.ready),
  .out_valid(weight_out.valid), .out_ready(weight_out.ready),
  .tap_weight(weight_out.tap_weight), .last_tap(weight_out.last_tap),
  .status(weight_out.status)
);
`default_nettype wire
